FILE: rtl/core/sftr_pkg.sv
package sftr_pkg;

  localparam logic [7:0]  GLYPH_FIRST        = 8'd32;
  localparam logic [7:0]  GLYPH_LAST         = 8'd90;
  localparam logic [7:0]  NEWLINE_CODE       = 8'd10;
  localparam logic [12:0] PANEL_LIMIT        = 13'd4096;
  localparam logic [12:0] PANEL_WIDTH_RESET  = 13'd960;
  localparam logic [12:0] PANEL_HEIGHT_RESET = 13'd540;
  localparam logic [2:0]  LAST_COL           = 3'd4;
  localparam logic [2:0]  LAST_ROW           = 3'd6;

  localparam logic CFG_PANEL_WIDTH  = 1'b0;
  localparam logic CFG_PANEL_HEIGHT = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH    = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_INIT     = 3'd2;
  localparam step_t STEP_DOT      = 3'd3;
  localparam step_t STEP_FLUSH    = 3'd4;
  localparam step_t STEP_ADVANCE  = 3'd5;
  localparam step_t STEP_NEWLINE  = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_DOT,
    OP_FLUSH,
    OP_ADVANCE,
    OP_NEWLINE
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_NEWLINE,
    COND_NO_DRAW,
    COND_MORE_DOTS
  } cond_t;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic newline;
    logic no_draw;
    logic more_dots;
    logic stall;
  } status_t;

  function automatic ctrl_t microcode(input step_t step);
    ctrl_t w;
    w = '{accept: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: STEP_FETCH};
    case (step)
      STEP_FETCH:    w = '{1'b1, OP_LOAD,    COND_NO_INPUT,  STEP_FETCH};
      STEP_DISPATCH: w = '{1'b0, OP_NONE,    COND_NEWLINE,   STEP_NEWLINE};
      STEP_INIT:     w = '{1'b0, OP_INIT,    COND_NO_DRAW,   STEP_FLUSH};
      STEP_DOT:      w = '{1'b0, OP_DOT,     COND_MORE_DOTS, STEP_DOT};
      STEP_FLUSH:    w = '{1'b0, OP_FLUSH,   COND_NEVER,     STEP_FETCH};
      STEP_ADVANCE:  w = '{1'b0, OP_ADVANCE, COND_ALWAYS,    STEP_FETCH};
      STEP_NEWLINE:  w = '{1'b0, OP_NEWLINE, COND_ALWAYS,    STEP_FETCH};
      default:       w = '{1'b0, OP_NONE,    COND_ALWAYS,    STEP_FETCH};
    endcase
    return w;
  endfunction

  // Columns packed {c4, c3, c2, c1, c0}; bit 0 of each column is the top row.
  function automatic logic [34:0] glyph_bits(input logic [5:0] idx);
    logic [34:0] g;
    g = '0;
    case (idx)
      6'd0:  g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      6'd1:  g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
      6'd2:  g = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
      6'd3:  g = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
      6'd4:  g = {7'h12, 7'h2A, 7'h7F, 7'h2A, 7'h24};
      6'd5:  g = {7'h62, 7'h64, 7'h08, 7'h13, 7'h23};
      6'd6:  g = {7'h50, 7'h22, 7'h55, 7'h49, 7'h36};
      6'd7:  g = {7'h00, 7'h00, 7'h03, 7'h05, 7'h00};
      6'd8:  g = {7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
      6'd9:  g = {7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
      6'd10: g = {7'h14, 7'h08, 7'h3E, 7'h08, 7'h14};
      6'd11: g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
      6'd12: g = {7'h00, 7'h00, 7'h30, 7'h50, 7'h00};
      6'd13: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      6'd14: g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
      6'd15: g = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
      6'd16: g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      6'd17: g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
      6'd18: g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
      6'd19: g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
      6'd20: g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
      6'd21: g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
      6'd22: g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      6'd23: g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
      6'd24: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      6'd25: g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      6'd26: g = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
      6'd27: g = {7'h00, 7'h00, 7'h36, 7'h56, 7'h00};
      6'd28: g = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
      6'd29: g = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
      6'd30: g = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
      6'd31: g = {7'h06, 7'h09, 7'h51, 7'h01, 7'h02};
      6'd32: g = {7'h3E, 7'h41, 7'h79, 7'h49, 7'h32};
      6'd33: g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      6'd34: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h7F};
      6'd35: g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
      6'd36: g = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F};
      6'd37: g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
      6'd38: g = {7'h01, 7'h09, 7'h09, 7'h09, 7'h7F};
      6'd39: g = {7'h7A, 7'h49, 7'h49, 7'h41, 7'h3E};
      6'd40: g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      6'd41: g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      6'd42: g = {7'h01, 7'h3F, 7'h41, 7'h40, 7'h20};
      6'd43: g = {7'h41, 7'h22, 7'h14, 7'h08, 7'h7F};
      6'd44: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
      6'd45: g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      6'd46: g = {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F};
      6'd47: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      6'd48: g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
      6'd49: g = {7'h5E, 7'h21, 7'h51, 7'h41, 7'h3E};
      6'd50: g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
      6'd51: g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
      6'd52: g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      6'd53: g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      6'd54: g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      6'd55: g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
      6'd56: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      6'd57: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      6'd58: g = {7'h43, 7'h45, 7'h49, 7'h51, 7'h61};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/scaled_font_text_rasterizer.sv
// Text rasterizer for a 5x7 column font with integer dot scaling.
// Input channel (in_valid/in_ready): one character per transfer with its
// string_start flag, origin, ink color and scale. The block keeps the cursor,
// line y and left margin between characters.
// Output channel (out_valid/out_ready): one clipped rectangle per visible lit
// dot, column-major, last_dot set on the final rectangle of a character.
// Configuration: cfg_write with cfg_index 0 sets panel_width, 1 panel_height.
// A sequencer steps a seven-word control program; a glyph character runs
// fetch, dispatch, glyph load, a dot step for each of the 35 font dots, flush
// and cursor advance; newline runs fetch, dispatch and the newline step, and
// codes without a glyph or with zero scale skip the dot steps. Each rectangle
// is held back one dot so last_dot is known. A stalled receiver holds the dot
// scan once a second visible dot is waiting.
// Synchronous reset clears the cursor, line and margin, empties the output
// and restores the panel size to 960 by 540.
module scaled_font_text_rasterizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               string_start,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic [7:0]         char_code,
  input  logic [3:0]         ink_color,
  input  logic [7:0]         scale,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        rect_x,
  output logic [11:0]        rect_y,
  output logic [7:0]         rect_w,
  output logic [7:0]         rect_h,
  output logic [3:0]         dot_color,
  output logic               last_dot
);
  import sftr_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  assign in_ready = ctrl.accept;

  sftr_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  sftr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .string_start (string_start),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .char_code    (char_code),
    .ink_color    (ink_color),
    .scale        (scale),
    .ctrl         (ctrl),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .dot_color    (dot_color),
    .last_dot     (last_dot)
  );

endmodule

FILE: rtl/core/sftr_sequencer.sv
module sftr_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  sftr_pkg::status_t status,
  output sftr_pkg::ctrl_t   ctrl
);
  import sftr_pkg::*;

  step_t step;
  step_t step_next;
  logic  taken;

  assign ctrl = microcode(step);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_INPUT:  taken = !status.in_valid;
      COND_NEWLINE:   taken = status.newline;
      COND_NO_DRAW:   taken = status.no_draw;
      COND_MORE_DOTS: taken = status.more_dots;
      default:        taken = 1'b0;
    endcase
    if (status.stall) begin
      step_next = step;
    end else if (taken) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: rtl/core/sftr_datapath.sv
module sftr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  input  logic               string_start,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic [7:0]         char_code,
  input  logic [3:0]         ink_color,
  input  logic [7:0]         scale,
  input  sftr_pkg::ctrl_t    ctrl,
  output sftr_pkg::status_t  status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        rect_x,
  output logic [11:0]        rect_y,
  output logic [7:0]         rect_w,
  output logic [7:0]         rect_h,
  output logic [3:0]         dot_color,
  output logic               last_dot
);
  import sftr_pkg::*;

  logic [12:0] panel_width;
  logic [12:0] panel_height;
  logic [15:0] cursor_x;
  logic [15:0] line_y;
  logic [15:0] left_margin;
  logic [15:0] dot_x;
  logic [15:0] dot_y;
  logic [7:0]  code;
  logic [7:0]  dot_size;
  logic [3:0]  color;
  logic [34:0] glyph;
  logic [2:0]  col;
  logic [2:0]  row;

  logic        pend_valid;
  logic [11:0] pend_x;
  logic [11:0] pend_y;
  logic [7:0]  pend_w;
  logic [7:0]  pend_h;

  logic [12:0] wlim;
  logic [12:0] hlim;
  logic [7:0]  glyph_idx;
  logic signed [17:0] x_start, x_end, x_lo, x_hi, x_span;
  logic signed [17:0] y_start, y_end, y_lo, y_hi, y_span;
  logic        visible;
  logic        emit;
  logic        out_free;
  logic        stall;
  logic        push;
  logic        load;
  logic [15:0] advance_x;
  logic [15:0] advance_y;

  assign wlim = (panel_width  > PANEL_LIMIT) ? PANEL_LIMIT : panel_width;
  assign hlim = (panel_height > PANEL_LIMIT) ? PANEL_LIMIT : panel_height;

  assign x_start = {{2{dot_x[15]}}, dot_x};
  assign x_end   = x_start + $signed({10'd0, dot_size});
  assign x_lo    = dot_x[15] ? 18'sd0 : x_start;
  assign x_hi    = (x_end > $signed({5'd0, wlim})) ? $signed({5'd0, wlim}) : x_end;
  assign x_span  = x_hi - x_lo;

  assign y_start = {{2{dot_y[15]}}, dot_y};
  assign y_end   = y_start + $signed({10'd0, dot_size});
  assign y_lo    = dot_y[15] ? 18'sd0 : y_start;
  assign y_hi    = (y_end > $signed({5'd0, hlim})) ? $signed({5'd0, hlim}) : y_end;
  assign y_span  = y_hi - y_lo;

  assign visible  = (x_lo < x_hi) && (y_lo < y_hi);
  assign emit     = glyph[0] && visible;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stall = 1'b0;
    push  = 1'b0;
    case (ctrl.op)
      OP_DOT: begin
        stall = emit && pend_valid && !out_free;
        push  = emit && pend_valid && out_free;
      end
      OP_FLUSH: begin
        stall = pend_valid && !out_free;
        push  = pend_valid && out_free;
      end
      default: begin
        stall = 1'b0;
        push  = 1'b0;
      end
    endcase
  end

  assign load      = (ctrl.op == OP_LOAD) && ctrl.accept && in_valid;
  assign glyph_idx = code - GLYPH_FIRST;
  assign advance_x = {6'd0, dot_size, 2'b00} + {7'd0, dot_size, 1'b0};
  assign advance_y = {5'd0, dot_size, 3'b000};

  assign status.in_valid  = in_valid;
  assign status.newline   = (code == NEWLINE_CODE);
  assign status.no_draw   = (code < GLYPH_FIRST) || (code > GLYPH_LAST) || (dot_size == 8'd0);
  assign status.more_dots = !((col == LAST_COL) && (row == LAST_ROW));
  assign status.stall     = stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RESET;
      panel_height <= PANEL_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      line_y      <= '0;
      left_margin <= '0;
    end else begin
      case (ctrl.op)
        OP_LOAD: begin
          if (load && string_start) begin
            left_margin <= origin_x;
            cursor_x    <= origin_x;
            line_y      <= origin_y;
          end
        end
        OP_ADVANCE: cursor_x <= cursor_x + advance_x;
        OP_NEWLINE: begin
          cursor_x <= left_margin;
          line_y   <= line_y + advance_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code     <= char_code;
      color    <= ink_color;
      dot_size <= scale;
    end
    if (ctrl.op == OP_INIT) begin
      glyph <= glyph_bits(glyph_idx[5:0]);
      dot_x <= cursor_x;
      dot_y <= line_y;
      col   <= '0;
      row   <= '0;
    end else if ((ctrl.op == OP_DOT) && !stall) begin
      glyph <= {1'b0, glyph[34:1]};
      if (row == LAST_ROW) begin
        row   <= '0;
        col   <= col + 3'd1;
        dot_y <= line_y;
        dot_x <= dot_x + {8'd0, dot_size};
      end else begin
        row   <= row + 3'd1;
        dot_y <= dot_y + {8'd0, dot_size};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if ((ctrl.op == OP_DOT) && emit && !stall) begin
      pend_valid <= 1'b1;
    end else if ((ctrl.op == OP_FLUSH) && push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_DOT) && emit && !stall) begin
      pend_x <= x_lo[11:0];
      pend_y <= y_lo[11:0];
      pend_w <= x_span[7:0];
      pend_h <= y_span[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rect_x    <= pend_x;
      rect_y    <= pend_y;
      rect_w    <= pend_w;
      rect_h    <= pend_h;
      dot_color <= color;
      last_dot  <= (ctrl.op == OP_FLUSH);
    end
  end

endmodule

FILE: bench/tb_scaled_font_text_rasterizer.sv
module tb_scaled_font_text_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import sftr_pkg::*;

  localparam int NUM_DIRECTED   = 23;
  localparam int NUM_TYPED      = 7;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  // Entry {c0, c1, c2, c3, c4} per glyph, bit 0 of a column is the top row.
  localparam logic [59*40-1:0] FONT_ROM = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  typedef struct packed {
    logic        start;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  code;
    logic [3:0]  ink;
    logic [7:0]  scale;
  } char_t;

  typedef struct packed {
    char_t      ch;
    logic       typed;
    logic [2:0] n_rects;
  } directed_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [3:0]  color;
    logic        last;
  } rect_t;

  logic               clk;
  logic               rst;
  logic               cfg_write = 1'b0;
  logic               cfg_index = CFG_PANEL_WIDTH;
  logic [12:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               string_start = 1'b0;
  logic signed [15:0] origin_x = '0;
  logic signed [15:0] origin_y = '0;
  logic [7:0]         char_code = '0;
  logic [3:0]         ink_color = '0;
  logic [7:0]         scale = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [11:0]        rect_x;
  logic [11:0]        rect_y;
  logic [7:0]         rect_w;
  logic [7:0]         rect_h;
  logic [3:0]         dot_color;
  logic               last_dot;

  scaled_font_text_rasterizer u_dut (.*);

  directed_t directed_rows [NUM_DIRECTED] = '{
    '{'{1'b1, 16'd0, 16'd0, 8'd33, 4'd15, 8'd255}, 1'b1, 3'd3},
    '{'{1'b0, 16'd0, 16'd0, NEWLINE_CODE, 4'd7, 8'd0}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd46, 4'd0, 8'd1}, 1'b1, 3'd4},
    '{'{1'b0, 16'd0, 16'd0, 8'd0, 4'd5, 8'd1}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd255, 4'd5, 8'd1}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, GLYPH_FIRST - 8'd1, 4'd6, 8'd2}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, GLYPH_LAST + 8'd1, 4'd6, 8'd2}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, GLYPH_FIRST, 4'd8, 8'd8}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd65, 4'd8, 8'd0}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, NEWLINE_CODE, 4'd1, 8'd255}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd72, 4'd1, 8'd1}, 1'b1, 3'd0},
    '{'{1'b1, 16'h8000, 16'h8000, 8'd65, 4'd2, 8'd255}, 1'b1, 3'd0},
    '{'{1'b1, 16'h7FFF, 16'h7FFF, 8'd35, 4'd2, 8'd255}, 1'b1, 3'd0},
    '{'{1'b1, 16'd100, 16'd50, GLYPH_LAST, 4'd9, 8'd3}, 1'b0, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd126, 4'd9, 8'd3}, 1'b1, 3'd0},
    '{'{1'b1, 16'd958, 16'd538, 8'd77, 4'd12, 8'd4}, 1'b0, 3'd0},
    '{'{1'b1, 16'hFFFD, 16'hFFFE, 8'd35, 4'd3, 8'd4}, 1'b0, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, NEWLINE_CODE, 4'd3, 8'd4}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd64, 4'd10, 8'd2}, 1'b0, 3'd0},
    '{'{1'b1, 16'd0, 16'd0, 8'd87, 4'd1, 8'd1}, 1'b0, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd48, 4'd14, 8'd7}, 1'b0, 3'd0},
    '{'{1'b1, 16'd20, 16'd30, NEWLINE_CODE, 4'd4, 8'd5}, 1'b1, 3'd0},
    '{'{1'b0, 16'd0, 16'd0, 8'd66, 4'd4, 8'd2}, 1'b0, 3'd0}
  };

  rect_t typed_rects [NUM_TYPED] = '{
    '{12'd510, 12'd0,   8'd255, 8'd255, 4'd15, 1'b0},
    '{12'd510, 12'd255, 8'd255, 8'd255, 4'd15, 1'b0},
    '{12'd510, 12'd510, 8'd255, 8'd30,  4'd15, 1'b1},
    '{12'd1,   12'd5,   8'd1,   8'd1,   4'd0,  1'b0},
    '{12'd1,   12'd6,   8'd1,   8'd1,   4'd0,  1'b0},
    '{12'd2,   12'd5,   8'd1,   8'd1,   4'd0,  1'b0},
    '{12'd2,   12'd6,   8'd1,   8'd1,   4'd0,  1'b1}
  };

  logic [12:0] panel_width;
  logic [12:0] panel_height;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] margin_x;
  rect_t       pending_rects [$];
  rect_t       char_rects [$];
  int          send_idle;
  int          recv_idle;
  int          errors;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit clip_span(input int start, input int len, input int lim,
                                   output int lo, output int n);
    int a;
    int b;
    a = (start < 0) ? 0 : start;
    b = start + len;
    if (b > lim) b = lim;
    lo = a;
    n = b - a;
    return a < b;
  endfunction

  function automatic int visible_limit(input logic [12:0] reg_value);
    return (reg_value > PANEL_LIMIT) ? int'(PANEL_LIMIT) : int'(reg_value);
  endfunction

  task automatic rasterize_char(input char_t c);
    int wlim;
    int hlim;
    int col;
    int row;
    int idx;
    int rx;
    int ry;
    int rw;
    int rh;
    logic [39:0] glyph;
    logic [7:0] column;
    logic [15:0] px;
    logic [15:0] py;
    rect_t r;
    char_rects.delete();
    wlim = visible_limit(panel_width);
    hlim = visible_limit(panel_height);
    if (c.start) begin
      margin_x = c.ox;
      pen_x = c.ox;
      pen_y = c.oy;
    end
    if (c.code == NEWLINE_CODE) begin
      pen_x = margin_x;
      pen_y = pen_y + 16'(c.scale) * 16'd8;
    end else begin
      if (c.code >= GLYPH_FIRST && c.code <= GLYPH_LAST && c.scale != 8'd0) begin
        idx = c.code - GLYPH_FIRST;
        glyph = FONT_ROM[(58 - idx) * 40 +: 40];
        for (col = 0; col < 5; col++) begin
          column = glyph[39 - 8 * col -: 8];
          for (row = 0; row < 7; row++) begin
            if (column[row]) begin
              px = pen_x + 16'(col * c.scale);
              py = pen_y + 16'(row * c.scale);
              if (clip_span($signed(px), c.scale, wlim, rx, rw) &&
                  clip_span($signed(py), c.scale, hlim, ry, rh)) begin
                r = '{12'(rx), 12'(ry), 8'(rw), 8'(rh), c.ink, 1'b0};
                char_rects.push_back(r);
              end
            end
          end
        end
        if (char_rects.size() > 0) begin
          r = char_rects.pop_back();
          r.last = 1'b1;
          char_rects.push_back(r);
        end
      end
      pen_x = pen_x + 16'(c.scale) * 16'd6;
    end
  endtask

  task automatic send_char(input char_t c, input bit typed, input int first, input int count);
    int k;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    string_start <= c.start;
    origin_x     <= c.ox;
    origin_y     <= c.oy;
    char_code    <= c.code;
    ink_color    <= c.ink;
    scale        <= c.scale;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    rasterize_char(c);
    if (typed) begin
      for (k = 0; k < count; k++) pending_rects.push_back(typed_rects[first + k]);
    end else begin
      foreach (char_rects[k]) pending_rects.push_back(char_rects[k]);
    end
    @(negedge clk);
  endtask

  function automatic char_t random_char(input int wlim, input int hlim);
    char_t c;
    int pick;
    c.start = ($urandom_range(7) == 0);
    pick = $urandom_range(99);
    if (pick < 75) c.code = 8'($urandom_range(GLYPH_LAST, GLYPH_FIRST));
    else if (pick < 87) c.code = NEWLINE_CODE;
    else c.code = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 70) c.scale = 8'($urandom_range(6, 1));
    else if (pick < 85) c.scale = 8'($urandom_range(40, 7));
    else if (pick < 92) c.scale = 8'd0;
    else c.scale = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      c.ox = 16'($urandom);
      c.oy = 16'($urandom);
    end else begin
      c.ox = 16'($urandom_range(wlim + 20) - 20);
      c.oy = 16'($urandom_range(hlim + 20) - 20);
    end
    c.ink = 4'($urandom_range(15));
    return c;
  endfunction

  task automatic stream_text(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_char(random_char(visible_limit(panel_width), visible_limit(panel_height)),
                1'b0, 0, 0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_panel(input logic [12:0] w, input logic [12:0] h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PANEL_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_PANEL_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    panel_width  = w;
    panel_height = h;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_rect(input rect_t got);
    rect_t want;
    if (pending_rects.size() == 0) begin
      $error("unexpected rectangle at x %0d y %0d", got.x, got.y);
      errors++;
    end else begin
      want = pending_rects.pop_front();
      check_field("rect_x", want.x, got.x);
      check_field("rect_y", want.y, got.y);
      check_field("rect_w", want.w, got.w);
      check_field("rect_h", want.h, got.h);
      check_field("dot_color", want.color, got.color);
      check_field("last_dot", want.last, got.last);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        check_rect('{rect_x, rect_y, rect_w, rect_h, dot_color, last_dot});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int i;
    int typed_next;
    rst = 1'b1;
    errors = 0;
    typed_next = 0;
    send_idle = 13;
    recv_idle = 71;
    panel_width  = PANEL_WIDTH_RESET;
    panel_height = PANEL_HEIGHT_RESET;
    pen_x = '0;
    pen_y = '0;
    margin_x = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_char(directed_rows[i].ch, directed_rows[i].typed, typed_next,
                directed_rows[i].n_rects);
      if (directed_rows[i].typed) typed_next += directed_rows[i].n_rects;
    end
    stream_text(80);

    settle();
    set_panel(13'd0, 13'd540);
    stream_text(10);

    settle();
    send_idle = 71;
    recv_idle = 13;
    set_panel(13'd4096, 13'd8191);
    stream_text(60);

    settle();
    set_panel(13'd1, 13'd1);
    stream_text(15);

    settle();
    set_panel(13'd8191, 13'd4096);
    stream_text(40);

    settle();
    send_idle = 0;
    recv_idle = 0;
    set_panel(13'd640, 13'd480);
    stream_text(90);

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sftr_pkg.sv
rtl/core/sftr_sequencer.sv
rtl/core/sftr_datapath.sv
rtl/core/scaled_font_text_rasterizer.sv
bench/tb_scaled_font_text_rasterizer.sv
